FILE: rtl/assert_macros.svh
// assertion macros used by the checker file ctm_checker
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off while in reset
`define CTM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctm assertion failed");

// next-cycle implication, sampled on the rising clock, off while in reset
`define CTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctm assertion failed");

`endif

FILE: rtl/ctm_pkg.sv
// types and constants of the node timeout monitor
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ctm_pkg;

    localparam int NODE_COUNT     = 4;
    localparam int ID_WIDTH       = 29;
    localparam int TIMEOUT_WIDTH  = 16;
    localparam int BYTE_WIDTH     = 8;
    localparam int OP_WIDTH       = 2;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 32;

    // node slots
    localparam int NODE_THERMAL = 0;
    localparam int NODE_BATTERY = 1;
    localparam int NODE_MOTOR   = 2;
    localparam int NODE_CHARGER = 3;

    // request opcodes
    localparam logic [OP_WIDTH-1:0] OP_FRAME = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_CHECK = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_THERMAL_ID = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BATTERY_ID = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MOTOR_ID   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CHARGER_ID = 3'd4;

    // reset values
    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET    = 16'd3000;
    localparam logic [ID_WIDTH-1:0]      THERMAL_ID_RESET = 29'h080;
    localparam logic [ID_WIDTH-1:0]      BATTERY_ID_RESET = 29'h7E3;
    localparam logic [ID_WIDTH-1:0]      MOTOR_ID_RESET   = 29'h41A;
    localparam logic [ID_WIDTH-1:0]      CHARGER_ID_RESET = 29'h18FF50E5;

    // battery first-byte codes
    localparam logic [BYTE_WIDTH-1:0] BYTE_CHARGE_ON  = 8'hFF;
    localparam logic [BYTE_WIDTH-1:0] BYTE_CHARGE_OFF = 8'h00;

    typedef struct packed {
        logic [OP_WIDTH-1:0]   op;
        logic [ID_WIDTH-1:0]   frame_id;
        logic [BYTE_WIDTH-1:0] first_byte;
    } req_t;

    typedef struct packed {
        logic thermal_error;
        logic battery_error;
        logic motor_error;
        logic charger_error;
        logic charging;
        logic fault_lamp;
        logic relay_closed;
    } rsp_t;

    typedef struct packed {
        logic [TIMEOUT_WIDTH-1:0]                 timeout_ms;
        logic [NODE_COUNT-1:0][ID_WIDTH-1:0]      node_id;
    } cfg_t;

endpackage

FILE: rtl/ctm_cfg_regs.sv
// configuration register file: timeout and the four node identifiers
// depends on ctm_pkg
`timescale 1ns / 1ps

module ctm_cfg_regs
    import ctm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:    cfg_next.timeout_ms = cfg_data[TIMEOUT_WIDTH-1:0];
                REG_THERMAL_ID: cfg_next.node_id[NODE_THERMAL] = cfg_data[ID_WIDTH-1:0];
                REG_BATTERY_ID: cfg_next.node_id[NODE_BATTERY] = cfg_data[ID_WIDTH-1:0];
                REG_MOTOR_ID:   cfg_next.node_id[NODE_MOTOR] = cfg_data[ID_WIDTH-1:0];
                REG_CHARGER_ID: cfg_next.node_id[NODE_CHARGER] = cfg_data[ID_WIDTH-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms            <= TIMEOUT_RESET;
            cfg_reg.node_id[NODE_THERMAL] <= THERMAL_ID_RESET;
            cfg_reg.node_id[NODE_BATTERY] <= BATTERY_ID_RESET;
            cfg_reg.node_id[NODE_MOTOR]   <= MOTOR_ID_RESET;
            cfg_reg.node_id[NODE_CHARGER] <= CHARGER_ID_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/ctm_core.sv
// request register and monitor state: silence counters, errors, charge mode, lamp, relay
// depends on ctm_pkg
`timescale 1ns / 1ps

module ctm_core
    import ctm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    input  logic rsp_free,
    output logic rsp_load,
    output rsp_t rsp_next
);

    localparam int LIM_WIDTH = (COUNT_WIDTH > TIMEOUT_WIDTH) ? COUNT_WIDTH : TIMEOUT_WIDTH;
    localparam logic [LIM_WIDTH-1:0] COUNT_MAX = LIM_WIDTH'({COUNT_WIDTH{1'b1}});

    logic                                   req_valid_reg;
    logic                                   req_valid_next;
    req_t                                   req_reg;
    logic [NODE_COUNT-1:0][COUNT_WIDTH-1:0] count_reg;
    logic [NODE_COUNT-1:0][COUNT_WIDTH-1:0] count_next;
    logic [NODE_COUNT-1:0]                  errors_reg;
    logic [NODE_COUNT-1:0]                  errors_next;
    logic                                   charge_reg;
    logic                                   charge_next;
    logic                                   lamp_reg;
    logic                                   lamp_next;
    logic                                   relay_reg;
    logic                                   relay_next;

    logic                                   step;
    logic                                   accept;
    logic [NODE_COUNT-1:0]                  id_match;
    logic [LIM_WIDTH-1:0]                   timeout_ext;
    logic [LIM_WIDTH-1:0]                   count_limit;

    assign step      = req_valid_reg && rsp_free;
    assign req_ready = !req_valid_reg || rsp_free;
    assign accept    = req_valid && req_ready;
    assign rsp_load  = step;

    assign req_valid_next = accept ? 1'b1 : (step ? 1'b0 : req_valid_reg);

    // counters saturate at the smaller of timeout and counter range
    assign timeout_ext = LIM_WIDTH'(cfg.timeout_ms);
    assign count_limit = (timeout_ext < COUNT_MAX) ? timeout_ext : COUNT_MAX;

    always_comb
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            id_match[i] = (cfg.node_id[i] == req_reg.frame_id);
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        errors_next = errors_reg;
        charge_next = charge_reg;
        lamp_next   = lamp_reg;
        relay_next  = relay_reg;
        unique case (req_reg.op)
            OP_FRAME:
            begin
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    if (id_match[i])
                    begin
                        count_next[i]  = '0;
                        errors_next[i] = 1'b0;
                    end
                end
                if (id_match[NODE_BATTERY])
                begin
                    if (req_reg.first_byte == BYTE_CHARGE_ON)
                    begin
                        charge_next = 1'b1;
                    end
                    else if (req_reg.first_byte == BYTE_CHARGE_OFF)
                    begin
                        charge_next = 1'b0;
                    end
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    if (LIM_WIDTH'(count_reg[i]) < count_limit)
                    begin
                        count_next[i] = count_reg[i] + COUNT_WIDTH'(1);
                    end
                end
            end
            OP_CHECK:
            begin
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    errors_next[i] = (LIM_WIDTH'(count_reg[i]) >= timeout_ext);
                end
                // charger only watched while charging
                if (!charge_reg)
                begin
                    errors_next[NODE_CHARGER] = 1'b0;
                end
                lamp_next  = |errors_next;
                relay_next = ~|errors_next;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.thermal_error = errors_next[NODE_THERMAL];
        rsp_next.battery_error = errors_next[NODE_BATTERY];
        rsp_next.motor_error   = errors_next[NODE_MOTOR];
        rsp_next.charger_error = errors_next[NODE_CHARGER];
        rsp_next.charging      = charge_next;
        rsp_next.fault_lamp    = lamp_next;
        rsp_next.relay_closed  = relay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            count_reg     <= '0;
            errors_reg    <= '0;
            charge_reg    <= 1'b0;
            lamp_reg      <= 1'b0;
            relay_reg     <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            if (step)
            begin
                count_reg  <= count_next;
                errors_reg <= errors_next;
                charge_reg <= charge_next;
                lamp_reg   <= lamp_next;
                relay_reg  <= relay_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_data;
        end
    end

endmodule

FILE: rtl/ctm_rsp_reg.sv
// response register with valid and ready
// depends on ctm_pkg
`timescale 1ns / 1ps

module ctm_rsp_reg
    import ctm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  rsp_t load_data,
    output logic free,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign free       = !valid_reg || rsp_ready;
    assign valid_next = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_reg);
    assign rsp_valid  = valid_reg;
    assign rsp_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

FILE: rtl/can_node_timeout_monitor.sv
// heartbeat timeout watchdog for four bus nodes (thermal, battery, motor, charger)
// depends on ctm_pkg, ctm_cfg_regs, ctm_core, ctm_rsp_reg
`timescale 1ns / 1ps

// every request (frame seen, millisecond tick, timeout check) yields exactly one
// response with the node error bits, charging mode, fault lamp and relay state as
// they stand after that request. a request is taken while the request register
// is empty or the response register is empty or being drained; it waits in the
// request register until the response register is free and then moves its result
// there, so throughput is one request per cycle while the response side does not
// stall. a matched frame clears that node's counter and error bit at once, but
// lamp and relay only follow at the next check. the charger is only checked while
// charging. counters saturate at the smaller of timeout_ms and the counter range.
// registers are meant to be written while the block is idle; the write channel is
// always ready and unknown indexes are ignored.

module can_node_timeout_monitor
    import ctm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      req_valid,
    output logic                      req_ready,
    input  req_t                      req_data,
    // response channel
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output rsp_t                      rsp_data,
    // register write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    cfg_t cfg;
    logic rsp_free;
    logic rsp_load;
    rsp_t rsp_next;

    // timeout and node identifiers
    ctm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // request register plus counters and flags
    ctm_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .rsp_next  (rsp_next)
    );

    // response register holds each result until the consumer takes it
    ctm_rsp_reg u_rsp_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rsp_load),
        .load_data (rsp_next),
        .free      (rsp_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

FILE: rtl/ctm_checker.sv
// port-level checks on the node timeout monitor, bound to the top level
// depends on ctm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctm_checker
    import ctm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // a stalled response stays offered
    `CTM_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // an empty response register never blocks requests
    `CTM_ASSERT_IMPL(a_no_stall_when_empty, clk, rst_n, !rsp_valid, req_ready)

    // lamp and relay never both on
    `CTM_ASSERT_IMPL(a_lamp_relay, clk, rst_n, rsp_valid && rsp_data.fault_lamp,
        !rsp_data.relay_closed)

    // errors are only raised by a check, which then opens the relay
    `CTM_ASSERT_IMPL(a_relay_no_error, clk, rst_n, rsp_valid && rsp_data.relay_closed,
        !rsp_data.thermal_error && !rsp_data.battery_error &&
        !rsp_data.motor_error && !rsp_data.charger_error)

endmodule

bind can_node_timeout_monitor ctm_checker u_ctm_checker (.*);

FILE: tb/sv/can_node_timeout_monitor_test.sv
// self-checking bench for the bus node timeout monitor: frames, ticks and checks
// depends on ctm_pkg and the can_node_timeout_monitor rtl
`timescale 1ns / 1ps

// requests come from a backlog queue that the sequence block fills; a driver
// presents them on the falling edge and a watcher samples both channels on the
// rising edge. every accepted request runs through a local status predictor and
// the predicted status is queued; every accepted response is compared with the
// oldest queued status, bit by bit. registers are only written while nothing is
// in flight. phases vary the idling of both sides, and one phase holds the
// response side off for a long stretch so the block backs up into its input.

module can_node_timeout_monitor_test;

    import ctm_pkg::*;

    localparam int COUNT_WIDTH = 16;
    localparam longint COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

    // op code the block leaves unused
    localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;

    // register indexes past the last mapped one
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED_FIRST = REG_CHARGER_ID + 1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED_LAST  = '1;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    // block ports; the inputs are at known values from time zero
    logic                      req_valid = 1'b0;
    logic                      req_ready;
    req_t                      req_data  = '0;
    logic                      rsp_valid;
    logic                      rsp_ready = 1'b0;
    rsp_t                      rsp_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    can_node_timeout_monitor #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // requests waiting to be driven, statuses waiting to come back
    req_t req_backlog [$];
    rsp_t status_due [$];

    int unsigned fail_count = 0;

    // idling knobs, changed by the sequence only while the block is idle
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // long receiver hold-off: the sequence bumps hold_seq, the ready process counts
    int unsigned hold_seq  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    // set by the watcher when the current request went in at the last rising edge
    bit req_taken = 1'b0;

    // ------------------------------------------------------------------
    // status predictor: its own copy of the registers and node state
    // ------------------------------------------------------------------
    logic [TIMEOUT_WIDTH-1:0] cfg_timeout;
    logic [ID_WIDTH-1:0]      cfg_node_id [NODE_COUNT];

    logic [COUNT_WIDTH-1:0]   quiet_ms [NODE_COUNT];
    logic [NODE_COUNT-1:0]    err_bits;
    logic                     charge_on;
    logic                     lamp_lit;
    logic                     relay_on;

    initial
    begin
        cfg_timeout = TIMEOUT_RESET;
        cfg_node_id[NODE_THERMAL] = THERMAL_ID_RESET;
        cfg_node_id[NODE_BATTERY] = BATTERY_ID_RESET;
        cfg_node_id[NODE_MOTOR]   = MOTOR_ID_RESET;
        cfg_node_id[NODE_CHARGER] = CHARGER_ID_RESET;
        for (int i = 0; i < NODE_COUNT; i++)
            quiet_ms[i] = '0;
        err_bits  = '0;
        charge_on = 1'b0;
        lamp_lit  = 1'b0;
        relay_on  = 1'b0;
    end

    function automatic rsp_t predict_status(req_t r);
        rsp_t                  s;
        logic [NODE_COUNT-1:0] late;
        longint                cap;
        cap = (longint'(cfg_timeout) < COUNT_MAX) ? longint'(cfg_timeout) : COUNT_MAX;
        case (r.op)
            OP_FRAME:
            begin
                // every node with a matching identifier is refreshed
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    if (cfg_node_id[i] == r.frame_id)
                    begin
                        quiet_ms[i] = '0;
                        err_bits[i] = 1'b0;
                        if (i == NODE_BATTERY)
                        begin
                            if (r.first_byte == BYTE_CHARGE_ON)
                                charge_on = 1'b1;
                            else if (r.first_byte == BYTE_CHARGE_OFF)
                                charge_on = 1'b0;
                        end
                    end
                end
            end
            OP_TICK:
            begin
                // saturate at the timeout, a counter above it just holds
                for (int i = 0; i < NODE_COUNT; i++)
                    if (longint'(quiet_ms[i]) < cap)
                        quiet_ms[i] = quiet_ms[i] + 1'b1;
            end
            OP_CHECK:
            begin
                for (int i = 0; i < NODE_COUNT; i++)
                    late[i] = (quiet_ms[i] >= cfg_timeout);
                // charger only counts while charging
                if (!charge_on)
                    late[NODE_CHARGER] = 1'b0;
                err_bits = late;
                lamp_lit = |late;
                relay_on = ~|late;
            end
            default:
            begin
                // unused op: state unchanged, status reported as is
            end
        endcase
        s.thermal_error = err_bits[NODE_THERMAL];
        s.battery_error = err_bits[NODE_BATTERY];
        s.motor_error   = err_bits[NODE_MOTOR];
        s.charger_error = err_bits[NODE_CHARGER];
        s.charging      = charge_on;
        s.fault_lamp    = lamp_lit;
        s.relay_closed  = relay_on;
        return s;
    endfunction

    function automatic void check_bit(string field, logic want, logic got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0b, got %0b", field, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver: falling edge, holds valid and payload until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_requests
        req_t next_req;
        logic next_valid;
        next_req   = req_data;
        next_valid = req_valid;
        if (!rst_n)
            next_valid = 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req   = req_backlog.pop_front();
                next_valid = 1'b1;
            end
            else
                next_valid = 1'b0;
        end
        req_valid <= next_valid;
        req_data  <= next_req;
    end

    // ------------------------------------------------------------------
    // response ready: random stalls, plus a counted hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_rsp_ready
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // watcher: rising edge, predicts on request, checks on response
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        rsp_t want;
        if (!rst_n)
            req_taken = 1'b0;
        else
        begin
            req_taken = req_valid && req_ready;
            if (req_taken)
                status_due.push_back(predict_status(req_data));
            if (rsp_valid && rsp_ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status response with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_bit("thermal_error", want.thermal_error, rsp_data.thermal_error);
                    check_bit("battery_error", want.battery_error, rsp_data.battery_error);
                    check_bit("motor_error", want.motor_error, rsp_data.motor_error);
                    check_bit("charger_error", want.charger_error, rsp_data.charger_error);
                    check_bit("charging", want.charging, rsp_data.charging);
                    check_bit("fault_lamp", want.fault_lamp, rsp_data.fault_lamp);
                    check_bit("relay_closed", want.relay_closed, rsp_data.relay_closed);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------

    // wait until nothing is queued, offered or outstanding, then wait out the drain period
    task automatic settle();
        @(posedge clk);
        while (req_backlog.size() != 0 || req_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write; the predictor follows at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] word);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_TIMEOUT)
            cfg_timeout = word[TIMEOUT_WIDTH-1:0];
        else if (idx >= REG_THERMAL_ID && idx <= REG_CHARGER_ID)
            cfg_node_id[idx - REG_THERMAL_ID] = word[ID_WIDTH-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // full register setup; unused upper data bits carry noise, and one
    // write goes to an unmapped index, which the block must ignore
    task automatic configure(input logic [TIMEOUT_WIDTH-1:0] tmo,
                             input logic [ID_WIDTH-1:0] thermal_id,
                             input logic [ID_WIDTH-1:0] battery_id,
                             input logic [ID_WIDTH-1:0] motor_id,
                             input logic [ID_WIDTH-1:0] charger_id);
        logic [CFG_DATA_WIDTH-1:0] word;
        word = $urandom();
        word[TIMEOUT_WIDTH-1:0] = tmo;
        write_reg(REG_TIMEOUT, word);
        word = $urandom();
        word[ID_WIDTH-1:0] = thermal_id;
        write_reg(REG_THERMAL_ID, word);
        word = $urandom();
        word[ID_WIDTH-1:0] = battery_id;
        write_reg(REG_BATTERY_ID, word);
        word = $urandom();
        word[ID_WIDTH-1:0] = motor_id;
        write_reg(REG_MOTOR_ID, word);
        word = $urandom();
        word[ID_WIDTH-1:0] = charger_id;
        write_reg(REG_CHARGER_ID, word);
        write_reg(CFG_IDX_WIDTH'($urandom_range(REG_UNMAPPED_LAST, REG_UNMAPPED_FIRST)),
                  $urandom());
    endtask

    task automatic queue_request(input logic [OP_WIDTH-1:0] op,
                                 input logic [ID_WIDTH-1:0] id,
                                 input logic [BYTE_WIDTH-1:0] first);
        req_t r;
        r.op         = op;
        r.frame_id   = id;
        r.first_byte = first;
        req_backlog.push_back(r);
    endtask

    function automatic logic [ID_WIDTH-1:0] random_id();
        logic [ID_WIDTH-1:0] v;
        v = $urandom();
        return v;
    endfunction

    // mostly ticks, frames mostly from known nodes and checks, with an occasional unused op
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r.frame_id   = random_id();
        r.first_byte = $urandom();
        pick = $urandom_range(99);
        if (pick < 40)
            r.op = OP_TICK;
        else if (pick < 72)
        begin
            r.op = OP_FRAME;
            if ($urandom_range(99) < 85)
                r.frame_id = cfg_node_id[$urandom_range(NODE_COUNT - 1)];
            case ($urandom_range(2))
                0:       r.first_byte = BYTE_CHARGE_ON;
                1:       r.first_byte = BYTE_CHARGE_OFF;
                default: ;
            endcase
        end
        else if (pick < 96)
            r.op = OP_CHECK;
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    task automatic queue_random(input int unsigned count);
        repeat (count) req_backlog.push_back(random_request());
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : run_sequence
        logic [ID_WIDTH-1:0] shared_id;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset registers: clean check, unused op, charging on and kept
        queue_request(OP_CHECK, '0, '0);
        queue_request(OP_UNUSED, '1, BYTE_CHARGE_ON);
        queue_request(OP_FRAME, BATTERY_ID_RESET, BYTE_CHARGE_ON);
        queue_request(OP_TICK, '1, '1);
        queue_request(OP_TICK, '0, '0);
        queue_request(OP_FRAME, BATTERY_ID_RESET, 8'h5A);
        // frame that matches no node
        queue_request(OP_FRAME, '1, BYTE_CHARGE_OFF);
        queue_request(OP_FRAME, THERMAL_ID_RESET, BYTE_CHARGE_OFF);
        queue_request(OP_FRAME, CHARGER_ID_RESET, BYTE_CHARGE_ON);
        queue_request(OP_FRAME, MOTOR_ID_RESET, BYTE_CHARGE_OFF);
        queue_request(OP_CHECK, '0, '0);
        queue_request(OP_TICK, '0, '0);
        queue_request(OP_TICK, '0, '0);
        queue_request(OP_TICK, '0, '0);
        settle();

        // timeout lowered below the counters: they hold, next check flags all
        write_reg(REG_TIMEOUT, 32'd2);
        queue_request(OP_TICK, '0, '0);
        queue_request(OP_CHECK, '0, '0);
        // frame between checks clears its error bit, lamp and relay wait
        queue_request(OP_FRAME, BATTERY_ID_RESET, BYTE_CHARGE_OFF);
        // not charging, so the charger drops out of the check
        queue_request(OP_CHECK, '0, '0);
        settle();

        // zero timeout: every check is a timeout
        write_reg(REG_TIMEOUT, 32'd0);
        queue_request(OP_TICK, '0, '0);
        queue_request(OP_CHECK, '0, '0);
        settle();

        // three nodes share one identifier, battery among them
        shared_id = '0;
        configure('0, shared_id, shared_id, shared_id, '1);
        queue_request(OP_FRAME, shared_id, BYTE_CHARGE_ON);
        queue_request(OP_CHECK, '0, '0);
        settle();

        // largest timeout
        write_reg(REG_TIMEOUT, 32'h0000_FFFF);
        queue_request(OP_FRAME, '1, BYTE_CHARGE_OFF);
        queue_request(OP_TICK, '0, '0);
        queue_request(OP_CHECK, '0, '0);
        settle();

        // random, no idling, random identifiers
        configure(TIMEOUT_WIDTH'($urandom_range(8, 1)),
                  random_id(), random_id(), random_id(), random_id());
        queue_random(150);
        settle();

        // random, sender idling, thermal and battery share an identifier
        send_idle_pct = 55;
        shared_id = random_id();
        configure(TIMEOUT_WIDTH'($urandom_range(12, 4)),
                  shared_id, shared_id, random_id(), random_id());
        queue_random(150);
        settle();

        // random, receiver stalling, reset identifiers
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        configure(TIMEOUT_WIDTH'($urandom_range(16, 1)),
                  THERMAL_ID_RESET, BATTERY_ID_RESET, MOTOR_ID_RESET, CHARGER_ID_RESET);
        queue_random(150);
        settle();

        // random, light idling on both sides, through the timeout extremes
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        configure('1, random_id(), random_id(), random_id(), random_id());
        queue_random(40);
        settle();
        configure('0, random_id(), random_id(), random_id(), random_id());
        queue_random(40);
        settle();
        configure(TIMEOUT_WIDTH'($urandom_range(10, 2)),
                  random_id(), random_id(), random_id(), random_id());
        queue_random(70);
        settle();

        // back-pressure: long receiver hold while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(TIMEOUT_WIDTH'($urandom_range(10, 3)),
                  random_id(), random_id(), random_id(), random_id());
        hold_seq = hold_seq + 1;
        queue_random(60);
        // sender pauses until every status is back, then resumes
        settle();
        queue_random(40);
        settle();

        if (fail_count == 0 && status_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin : run_limit
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
